@@ sv/cidl_pkg.sv @@
package cidl_pkg;

    // Field widths of the channels.
    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned DELAY_MS_W = 18;
    localparam int unsigned SPM_W      = 8;

    // Delay arithmetic: delay_ms * samples_per_ms gives samples in Q.10.
    localparam int unsigned FRAC_W = 10;
    localparam int unsigned DW     = DELAY_MS_W + SPM_W;

    localparam logic [SPM_W-1:0] SPM_RESET = 8'd48;

    // Polynomial datapath widths.
    localparam int unsigned A_W    = SAMPLE_W + 1;
    localparam int unsigned COEF_W = SAMPLE_W + 4;
    localparam int unsigned T2_W   = 2 * FRAC_W;
    localparam int unsigned T3_W   = 3 * FRAC_W;
    localparam int unsigned PROD_W = COEF_W + T3_W + 1;
    localparam int unsigned ACC_W  = PROD_W + 1;
    localparam int unsigned Q_W    = ACC_W - 31;

    localparam logic signed [ACC_W-1:0]    ROUND_HALF = 60'sh000000040000000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    // Shared multiplier operand selection.
    typedef enum logic [2:0] {
        MS_NONE,
        MS_TT,
        MS_T3,
        MS_A,
        MS_B,
        MS_C
    } t_msel;

    // Accumulator operations.
    typedef enum logic [2:0] {
        AOP_NONE,
        AOP_INIT,
        AOP_ADD20,
        AOP_ADD10,
        AOP_ADD0
    } t_aop;

    typedef struct packed {
        logic  in_ready;
        logic  wr;
        logic  rd;
        logic  coef;
        t_msel msel;
        t_aop  aop;
        logic  out_ld;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_status;

endpackage

@@ sv/cidl_if.sv @@
interface cidl_in_if import cidl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] write_sample;
    logic [DELAY_MS_W-1:0]      delay_ms;

    modport source (output valid, output write_sample, output delay_ms, input ready);
    modport sink   (input valid, input write_sample, input delay_ms, output ready);
endinterface

interface cidl_out_if import cidl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] read_sample;

    modport source (output valid, output read_sample, input ready);
    modport sink   (input valid, input read_sample, output ready);
endinterface

interface cidl_cfg_if import cidl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SPM_W-1:0] samples_per_ms;

    modport source (output valid, output samples_per_ms, input ready);
    modport sink   (input valid, input samples_per_ms, output ready);
endinterface

@@ sv/cidl_ctrl.sv @@
module cidl_ctrl import cidl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_WRITE = 13'b0000000000010,
        S_RD0   = 13'b0000000000100,
        S_RD1   = 13'b0000000001000,
        S_RD2   = 13'b0000000010000,
        S_RD3   = 13'b0000000100000,
        S_LAST  = 13'b0000001000000,
        S_COEF  = 13'b0000010000000,
        S_MULA  = 13'b0000100000000,
        S_MULB  = 13'b0001000000000,
        S_MULC  = 13'b0010000000000,
        S_SUM   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.wr        = 1'b0;
        o_cmd.rd        = 1'b0;
        o_cmd.coef      = 1'b0;
        o_cmd.msel      = MS_NONE;
        o_cmd.aop       = AOP_NONE;
        o_cmd.out_ld    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = S_RD0;
            end
            S_RD0: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LAST;
            end
            S_LAST: begin
                o_cmd.msel = MS_TT;
                n_state    = S_COEF;
            end
            S_COEF: begin
                o_cmd.coef = 1'b1;
                o_cmd.msel = MS_T3;
                n_state    = S_MULA;
            end
            S_MULA: begin
                o_cmd.msel = MS_A;
                o_cmd.aop  = AOP_INIT;
                n_state    = S_MULB;
            end
            S_MULB: begin
                o_cmd.msel = MS_B;
                o_cmd.aop  = AOP_ADD20;
                n_state    = S_MULC;
            end
            S_MULC: begin
                o_cmd.msel = MS_C;
                o_cmd.aop  = AOP_ADD10;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.aop = AOP_ADD0;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_status.in_valid) |=> (r_state == S_WRITE))
        else $error("accepted item did not start the store write");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |=> (r_state == S_IDLE))
        else $error("result load did not return to idle");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_status.out_free) |=> (r_state == S_OUT && !o_cmd.in_ready))
        else $error("result left the output stage while the output register was full");
`endif

endmodule

@@ sv/cidl_datapath.sv @@
module cidl_datapath import cidl_pkg::*; #(
    parameter int unsigned DEPTH = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    cidl_in_if.sink    i_in,
    cidl_out_if.source o_out,
    cidl_cfg_if.sink   i_cfg
);

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned FW   = $clog2(DEPTH + 1);
    localparam int unsigned D_LO = 1 << FRAC_W;
    localparam int unsigned D_HI = (DEPTH - 4) << FRAC_W;

    // Configuration register.
    logic [SPM_W-1:0] r_spm;

    // Control state.
    logic [AW-1:0] r_wptr;
    logic [FW-1:0] r_fill;
    logic [1:0]    r_j;
    logic          r_cap;
    logic          r_out_valid;

    // Payload.
    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [DELAY_MS_W-1:0]      r_delay;
    logic [AW-1:0]              r_di;
    logic [FRAC_W-1:0]          r_t;
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic                       r_rvld;
    logic signed [SAMPLE_W-1:0] r_p [4];
    logic signed [A_W-1:0]      r_a;
    logic signed [COEF_W-1:0]   r_b;
    logic signed [COEF_W-1:0]   r_c;
    logic [T2_W-1:0]            r_t2;
    logic [T3_W-1:0]            r_t3;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                       w_accept;
    logic [DW-1:0]              w_d;
    logic [AW-1:0]              n_di;
    logic [FRAC_W-1:0]          n_t;
    logic [AW-1:0]              w_k;
    logic [AW:0]                w_sum;
    logic [AW:0]                w_idx;
    logic signed [COEF_W-1:0]   w_e0, w_e1, w_e2, w_e3;
    logic signed [COEF_W-1:0]   w_mx;
    logic [T3_W-1:0]            w_my;
    logic signed [T3_W:0]       w_my_s;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    w_prod_x;
    logic signed [ACC_W-1:0]    w_rnd;
    logic signed [Q_W-1:0]      w_q;
    logic signed [SAMPLE_W-1:0] w_sat;

    assign w_accept         = i_in.valid && i_cmd.in_ready;
    assign i_in.ready       = i_cmd.in_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.read_sample = r_out_data;
    assign o_status.in_valid = i_in.valid;
    assign o_status.out_free = !r_out_valid || o_out.ready;

    // Delay in samples, clamped to 1 .. DEPTH-4.
    assign w_d = DW'(r_delay) * DW'(r_spm);

    always_comb begin
        if (w_d < DW'(D_LO)) begin
            n_di = AW'(1);
            n_t  = '0;
        end else if (w_d > DW'(D_HI)) begin
            n_di = AW'(DEPTH - 4);
            n_t  = '0;
        end else begin
            n_di = AW'(w_d >> FRAC_W);
            n_t  = w_d[FRAC_W-1:0];
        end
    end

    // Tap k lies k samples behind the newest one; the pointer already points past it.
    assign w_k   = r_di - AW'(1) + AW'(r_j);
    assign w_sum = {1'b0, r_wptr} + (AW+1)'(DEPTH - 1) - {1'b0, w_k};
    assign w_idx = (w_sum >= (AW+1)'(DEPTH)) ? (w_sum - (AW+1)'(DEPTH)) : w_sum;

    assign w_e0 = COEF_W'(r_p[0]);
    assign w_e1 = COEF_W'(r_p[1]);
    assign w_e2 = COEF_W'(r_p[2]);
    assign w_e3 = COEF_W'(r_p[3]);

    always_comb begin
        case (i_cmd.msel)
            MS_TT: begin
                w_mx = COEF_W'(r_t);
                w_my = T3_W'(r_t);
            end
            MS_T3: begin
                w_mx = COEF_W'(r_t);
                w_my = T3_W'(r_prod[T2_W-1:0]);
            end
            MS_A: begin
                w_mx = COEF_W'(r_a);
                w_my = T3_W'(r_t);
            end
            MS_B: begin
                w_mx = r_b;
                w_my = T3_W'(r_t2);
            end
            MS_C: begin
                w_mx = r_c;
                w_my = r_t3;
            end
            default: begin
                w_mx = '0;
                w_my = '0;
            end
        endcase
    end

    assign w_my_s = $signed({1'b0, w_my});
    assign w_prod = w_mx * w_my_s;
    assign w_prod_x = ACC_W'(r_prod);

    // Halve with rounding of ties toward plus infinity, then saturate.
    assign w_rnd = r_acc + ROUND_HALF;
    assign w_q   = w_rnd[ACC_W-1:31];

    always_comb begin
        if (w_q > Q_W'(SAMPLE_MAX)) begin
            w_sat = SAMPLE_MAX;
        end else if (w_q < Q_W'(SAMPLE_MIN)) begin
            w_sat = SAMPLE_MIN;
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm       <= SPM_RESET;
            r_wptr      <= '0;
            r_fill      <= '0;
            r_j         <= '0;
            r_cap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_spm <= i_cfg.samples_per_ms;
            end
            if (i_cmd.wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
                if (r_fill != FW'(DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
                r_j <= '0;
            end else if (i_cmd.rd) begin
                r_j <= r_j + 2'd1;
            end
            r_cap <= i_cmd.rd;
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample store: one write or one read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_wptr] <= r_sample;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_in.write_sample;
            r_delay  <= i_in.delay_ms;
        end
        if (i_cmd.wr) begin
            r_di <= n_di;
            r_t  <= n_t;
        end
        if (i_cmd.rd) begin
            // Entries older than the fill count were never written and read as zero.
            r_rvld <= (FW'(w_k) < r_fill);
        end
        if (r_cap) begin
            r_p[0] <= r_p[1];
            r_p[1] <= r_p[2];
            r_p[2] <= r_p[3];
            r_p[3] <= r_rvld ? r_rdata : '0;
        end
        if (i_cmd.coef) begin
            r_a <= A_W'(w_e2) - A_W'(w_e0);
            r_b <= (w_e0 <<< 1) - (w_e1 <<< 2) - w_e1 + (w_e2 <<< 2) - w_e3;
            r_c <= w_e1 + (w_e1 <<< 1) - w_e2 - (w_e2 <<< 1) + w_e3 - w_e0;
        end
        // The product register holds t*t while the cube is formed, then t^3.
        if (i_cmd.msel == MS_T3) begin
            r_t2 <= r_prod[T2_W-1:0];
        end
        if (i_cmd.msel == MS_A) begin
            r_t3 <= r_prod[T3_W-1:0];
        end
        r_prod <= w_prod;
        case (i_cmd.aop)
            AOP_INIT:  r_acc <= ACC_W'(r_p[1]) <<< 31;
            AOP_ADD20: r_acc <= r_acc + (w_prod_x <<< 20);
            AOP_ADD10: r_acc <= r_acc + (w_prod_x <<< 10);
            AOP_ADD0:  r_acc <= r_acc + w_prod_x;
            default:   r_acc <= r_acc;
        endcase
        if (i_cmd.out_ld) begin
            r_out_data <= w_sat;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (w_idx < (AW+1)'(DEPTH)))
        else $error("tap address outside the store");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond store depth");

    a_delay_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_di != '0 && r_di <= AW'(DEPTH - 4)))
        else $error("integer delay outside the clamp range during tap reads");
`endif

endmodule

@@ sv/cubic_interpolated_delay_line_unit.sv @@
// Channel  Direction  Handshake        Payload
// i_in     sink       valid / ready    write_sample (s24 Q1.23), delay_ms (u18, 1/1024 ms)
// o_out    source     valid / ready    read_sample (s24 Q1.23)
// i_cfg    sink       valid / ready    samples_per_ms (u8), ready is always high
//
// Each item runs one store write, four tap reads through the single store port,
// and five products on one shared multiplier; a new input is accepted only
// after the result has been loaded into the output register.
// Reset is synchronous and active low; the store gets no clearing pass, since a
// fill count makes taps older than the written history read as zero.
// A result that waits in the output register holds the block in its final step.
module cubic_interpolated_delay_line_unit import cidl_pkg::*; #(
    parameter int unsigned DEPTH = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cidl_in_if.sink    i_in,
    cidl_out_if.source o_out,
    cidl_cfg_if.sink   i_cfg
);

    // The controller sequences the item: accept, write the new sample, read the
    // four neighboring taps, form the Catmull-Rom coefficients, then evaluate
    // 2*p1*2^30 + a*t*2^20 + b*t^2*2^10 + c*t^3 one product at a time.
    t_cmd    w_cmd;
    t_status w_status;

    cidl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // The datapath holds the store, the write pointer and fill count, the
    // samples-per-millisecond register, the shared multiplier, the accumulator
    // and the output register that parts the result from the next item.
    cidl_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg)
    );

endmodule

@@ verif/cubic_interpolated_delay_line_unit_test.sv @@
`timescale 1ns / 100ps

module cubic_interpolated_delay_line_unit_test import cidl_pkg::*;;

    // The line depth matches the default of the unit under test.
    localparam int unsigned LINE_DEPTH = 8192;
    localparam int unsigned ADDR_W     = 13;
    localparam int unsigned CLAMP_HI   = LINE_DEPTH - 4;
    localparam int unsigned PHASES     = 8;
    localparam int unsigned PHASE_LEN  = 225;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic {
        STEP_SAMPLE,
        STEP_SPM
    } t_step_kind;

    // One row of the directed part. A pinned row carries its read value by hand.
    typedef struct packed {
        t_step_kind            kind;
        t_sample               sample;
        logic [DELAY_MS_W-1:0] dly;
        logic [SPM_W-1:0]      spm;
        logic                  pinned;
        t_sample               want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    cidl_in_if  in_ch  ();
    cidl_out_if out_ch ();
    cidl_cfg_if cfg_ch ();

    cubic_interpolated_delay_line_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the delay line: sample store, write head and current scale.
    t_sample           line_store [LINE_DEPTH];
    logic [ADDR_W-1:0] head;
    logic [SPM_W-1:0]  spm_now;
    int unsigned       fill;

    t_sample pending_reads [$];
    int      mismatch_count;
    bit      no_idle;

    // Reset read is zero. Each read at delay 0 returns the sample written one step
    // earlier. The two rows with delay 32 read the Catmull-Rom midpoint through
    // min, max, max, min and its mirror, which overshoots and must saturate.
    t_row directed_rows [25] = '{
        '{STEP_SAMPLE, SAMPLE_MAX,    18'd0,      8'd0,   1'b1, 24'sd0},
        '{STEP_SAMPLE, SAMPLE_MIN,    18'd0,      8'd0,   1'b1, SAMPLE_MAX},
        '{STEP_SAMPLE, SAMPLE_MAX,    18'd0,      8'd0,   1'b1, SAMPLE_MIN},
        '{STEP_SAMPLE, 24'sd0,        18'd0,      8'd0,   1'b1, SAMPLE_MAX},
        '{STEP_SAMPLE, -24'sd1,       18'd0,      8'd0,   1'b1, 24'sd0},
        '{STEP_SAMPLE, 24'sd1,        18'd0,      8'd0,   1'b1, -24'sd1},
        '{STEP_SAMPLE, SAMPLE_MIN,    18'd0,      8'd0,   1'b1, 24'sd1},
        '{STEP_SAMPLE, SAMPLE_MAX,    18'd0,      8'd0,   1'b1, SAMPLE_MIN},
        '{STEP_SAMPLE, SAMPLE_MAX,    18'd0,      8'd0,   1'b1, SAMPLE_MAX},
        '{STEP_SAMPLE, SAMPLE_MIN,    18'd32,     8'd0,   1'b1, SAMPLE_MAX},
        '{STEP_SAMPLE, SAMPLE_MIN,    18'd0,      8'd0,   1'b1, SAMPLE_MIN},
        '{STEP_SAMPLE, SAMPLE_MAX,    18'd32,     8'd0,   1'b1, SAMPLE_MIN},
        '{STEP_SAMPLE, 24'sh123456,   18'h3FFFF,  8'd0,   1'b1, 24'sd0},
        '{STEP_SAMPLE, 24'sh3A5C17,   18'd100,    8'd0,   1'b0, 24'sd0},
        '{STEP_SAMPLE, -24'sh2468AC,  18'd1000,   8'd0,   1'b0, 24'sd0},
        '{STEP_SPM,    24'sd0,        18'd0,      8'd0,   1'b0, 24'sd0},
        '{STEP_SAMPLE, 24'sh000ABC,   18'h3FFFF,  8'd0,   1'b1, -24'sh2468AC},
        '{STEP_SPM,    24'sd0,        18'd0,      8'd255, 1'b0, 24'sd0},
        '{STEP_SAMPLE, SAMPLE_MAX,    18'h3FFFF,  8'd0,   1'b1, 24'sd0},
        '{STEP_SAMPLE, SAMPLE_MIN,    18'd5,      8'd0,   1'b0, 24'sd0},
        '{STEP_SPM,    24'sd0,        18'd0,      8'd192, 1'b0, 24'sd0},
        '{STEP_SAMPLE, 24'sh400000,   18'd0,      8'd0,   1'b1, SAMPLE_MIN},
        '{STEP_SPM,    24'sd0,        18'd0,      8'd1,   1'b0, 24'sd0},
        '{STEP_SAMPLE, 24'sd1,        18'd1023,   8'd0,   1'b1, 24'sh400000},
        '{STEP_SAMPLE, 24'sd2,        18'd2047,   8'd0,   1'b0, 24'sd0}
    };

    // Scale of each random phase; the last one is replaced by a random legal value.
    logic [SPM_W-1:0] phase_spm [PHASES] = '{
        8'd1, 8'd192, 8'd48, 8'd0, 8'd255, 8'd44, 8'd96, 8'd0
    };

    // Tap at the given age behind the newest sample. Entries never written
    // still hold zero, as after reset.
    function automatic longint tap_at(input logic [ADDR_W-1:0] age);
        logic [ADDR_W-1:0] idx;
        idx = head - 1'b1 - age;
        return longint'(line_store[idx]);
    endfunction

    // Writes the new sample and returns the Catmull-Rom read at the scaled delay.
    function automatic t_sample interpolate_read(input t_sample sample,
                                                 input logic [DELAY_MS_W-1:0] dly);
        longint unsigned   span;
        logic [ADDR_W-1:0] whole;
        longint            t, p0, p1, p2, p3, a, b, c, acc, q;
        line_store[head] = sample;
        head = head + 1'b1;

        // Delay in samples with FRAC_W fraction bits, held inside the usable window.
        span = dly;
        span = span * spm_now;
        if (span < (64'd1 << FRAC_W))
            span = 64'd1 << FRAC_W;
        if (span > (64'(CLAMP_HI) << FRAC_W))
            span = 64'(CLAMP_HI) << FRAC_W;
        whole = span[FRAC_W +: ADDR_W];
        t = longint'(span[FRAC_W-1:0]);

        p0 = tap_at(whole - 1'b1);
        p1 = tap_at(whole);
        p2 = tap_at(whole + 1'b1);
        p3 = tap_at(whole + 2'd2);
        a = p2 - p0;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = -p0 + 3 * p1 - 3 * p2 + p3;

        // The polynomial is scaled by 2^30, then halved with round half up.
        acc = 2 * p1 * 64'sd1073741824 + a * t * 64'sd1048576
            + b * t * t * 64'sd1024 + c * t * t * t;
        q = (acc + 64'sd1073741824) >>> 31;
        if (q > longint'(SAMPLE_MAX))
            q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN))
            q = longint'(SAMPLE_MIN);
        return q[SAMPLE_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns  %s", $time, what);
        mismatch_count++;
    endtask

    // Offers one sample with random idle cycles ahead of it. Valid stays high
    // after the transfer, so back-to-back samples keep it high without a gap.
    task automatic send_item(input t_sample sample, input logic [DELAY_MS_W-1:0] dly,
                             input logic pinned, input t_sample want);
        t_sample predicted;
        while (!no_idle && $urandom_range(0, 99) < 35) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.write_sample <= sample;
        in_ch.delay_ms     <= dly;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predicted = interpolate_read(sample, dly);
        pending_reads.push_back(pinned ? want : predicted);
        fill++;
    endtask

    // The scale changes only once every outstanding read has come back.
    task automatic load_spm(input logic [SPM_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.samples_per_ms <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        spm_now = value;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: ready drops in about a third of the cycles unless told not to.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge i_clk) begin : read_check
        t_sample want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_reads.size() == 0) begin
                flag_mismatch($sformatf("read_sample %0d with no read outstanding",
                                        out_ch.read_sample));
            end else begin
                want = pending_reads.pop_front();
                if (out_ch.read_sample !== want)
                    flag_mismatch($sformatf("read_sample got %0d, want %0d",
                                            out_ch.read_sample, want));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_sample               sample;
        logic [DELAY_MS_W-1:0] dly;
        longint unsigned       target;
        int unsigned           reach;
        int unsigned           roll;

        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.write_sample    = '0;
        in_ch.delay_ms        = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.samples_per_ms = '0;
        foreach (line_store[k])
            line_store[k] = '0;
        head           = '0;
        spm_now        = SPM_RESET;
        fill           = 0;
        mismatch_count = 0;
        no_idle        = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == STEP_SPM)
                load_spm(directed_rows[k].spm);
            else
                send_item(directed_rows[k].sample, directed_rows[k].dly,
                          directed_rows[k].pinned, directed_rows[k].want);
        end

        phase_spm[PHASES-1] = SPM_W'($urandom_range(2, 191));
        for (int phase = 0; phase < PHASES; phase++) begin
            load_spm(phase_spm[phase]);
            // One whole phase runs with both sides at full rate.
            no_idle = (phase == 2);
            for (int n = 0; n < PHASE_LEN; n++) begin
                roll = $urandom_range(0, 9);
                if (roll < 2) begin
                    case ($urandom_range(0, 3))
                        0:       sample = SAMPLE_MAX;
                        1:       sample = SAMPLE_MIN;
                        2:       sample = '0;
                        default: sample = '1;
                    endcase
                end else if (roll < 4) begin
                    sample = SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
                end else begin
                    sample = SAMPLE_W'($urandom());
                end

                // Most delays land inside the history written so far; a few are
                // short, and some are raw so that every delay bit toggles.
                roll = $urandom_range(0, 99);
                if (roll < 15 || spm_now == 0) begin
                    dly = DELAY_MS_W'($urandom_range(0, (1 << DELAY_MS_W) - 1));
                end else begin
                    reach = (roll < 35) ? 4 : ((fill + 4 < CLAMP_HI) ? fill + 4 : CLAMP_HI);
                    target = $urandom_range(0, (reach << FRAC_W) + 1023);
                    target = target / spm_now;
                    dly = (target >= (1 << DELAY_MS_W)) ? '1 : target[DELAY_MS_W-1:0];
                end
                send_item(sample, dly, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        // A stray result would show up within one item time.
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cidl_pkg.sv
sv/cidl_if.sv
sv/cidl_ctrl.sv
sv/cidl_datapath.sv
sv/cubic_interpolated_delay_line_unit.sv
verif/cubic_interpolated_delay_line_unit_test.sv
